// File: sv/api_pkg.sv
// Package for the affine warp inverse core: field widths, register codes and
// the packed request and response word types. No dependencies.
`timescale 1ns / 1ps

package api_pkg;

   localparam int API_PARAM_WIDTH   = 32;
   localparam int API_FRAC_BITS     = 16;
   localparam int API_MIN_DET_WIDTH = 16;
   localparam int API_ADDR_WIDTH    = 3;
   localparam int API_DATA_WIDTH    = 32;

   localparam logic [API_MIN_DET_WIDTH-1:0] API_MIN_DET_RESET = 16'd1;

   // Register indexes, taken from paddr above the byte offset.
   localparam logic [0:0] API_REG_MIN_DET = 1'b0;

   typedef struct packed {
      logic signed [API_PARAM_WIDTH-1:0] m00_delta;
      logic signed [API_PARAM_WIDTH-1:0] m10;
      logic signed [API_PARAM_WIDTH-1:0] m01;
      logic signed [API_PARAM_WIDTH-1:0] m11_delta;
      logic signed [API_PARAM_WIDTH-1:0] shift_u;
      logic signed [API_PARAM_WIDTH-1:0] shift_v;
   } api_req_type;

   typedef struct packed {
      logic signed [API_PARAM_WIDTH-1:0] inv_m00_delta;
      logic signed [API_PARAM_WIDTH-1:0] inv_m10;
      logic signed [API_PARAM_WIDTH-1:0] inv_m01;
      logic signed [API_PARAM_WIDTH-1:0] inv_m11_delta;
      logic signed [API_PARAM_WIDTH-1:0] inv_shift_u;
      logic signed [API_PARAM_WIDTH-1:0] inv_shift_v;
      logic                              singular;
   } api_rsp_type;

endpackage

// File: sv/affine_param_inverse_core.sv
// Inverse of a 2D affine warp: determinant, pipelined restoring divider,
// split multipliers and saturation. Depends on api_pkg.
// Most of the pipeline from accept to result is the divider, which retires one
// quotient bit per stage.
// A new word is accepted every cycle; busy stays low and results cannot stall.
// Synchronous reset clears all valid bits and sets min_det to one.
`timescale 1ns / 1ps

module affine_param_inverse_core
   import api_pkg::*;
#(
   parameter int FRAC_BITS = API_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  api_req_type               req_word,
   output logic                      rsp_strobe,
   output api_rsp_type               rsp_word,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [API_ADDR_WIDTH-1:0] paddr,
   input  logic [API_DATA_WIDTH-1:0] pwdata,
   output logic [API_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int W   = API_PARAM_WIDTH;
   localparam int RW  = W + 1;
   localparam int PW  = 2 * RW + 1;
   localparam int QW  = RW + FRAC_BITS;
   localparam int IW  = QW + 1;
   localparam int L   = IW / 2;
   localparam int PLW = L + 1 + W;
   localparam int PHW = IW - L + W;
   localparam int PRW = IW + W;
   localparam int TW  = PRW + 2;
   localparam int LATENCY = QW + 8;

   localparam logic signed [RW-1:0] ONE_R = RW'(64'd1 << FRAC_BITS);
   localparam logic signed [TW-1:0] ONE_T = TW'(64'd1 << FRAC_BITS);

   typedef struct packed {
      logic                       singular;
      logic [3:0]                 neg;
      logic signed [W-1:0]        u;
      logic signed [W-1:0]        v;
      logic [63:0]                d;
      logic [3:0][63:0]           rem;
      logic [3:0][QW-1:0]         nq;
   } div_type;

   function automatic logic signed [W-1:0] sat_w(input logic signed [TW-1:0] x);
      logic hi_ones;
      logic hi_zeros;
      hi_ones  = &x[TW-1:W-1];
      hi_zeros = ~|x[TW-1:W-1];
      if (hi_ones || hi_zeros) begin
         sat_w = x[W-1:0];
      end else begin
         sat_w = {x[TW-1], {(W-1){~x[TW-1]}}};
      end
   endfunction

   // Configuration register.
   logic [API_MIN_DET_WIDTH-1:0] min_det_ff;
   logic                         csr_write;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[API_ADDR_WIDTH-1:2] == API_REG_MIN_DET);
   assign prdata    = (paddr[API_ADDR_WIDTH-1:2] == API_REG_MIN_DET) ?
                      API_DATA_WIDTH'(min_det_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_det_ff <= API_MIN_DET_RESET;
      end else if (csr_write) begin
         min_det_ff <= pwdata[API_MIN_DET_WIDTH-1:0];
      end
   end

   logic accept;
   assign accept = start && !busy;

   // Stage 1: matrix entries in full form.
   logic                 s1_valid_ff;
   logic signed [RW-1:0] r00_ff, r01_ff, r10_ff, r11_ff;
   logic signed [W-1:0]  s1_u_ff, s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      r00_ff  <= ONE_R + RW'(req_word.m00_delta);
      r10_ff  <= RW'(req_word.m10);
      r01_ff  <= RW'(req_word.m01);
      r11_ff  <= ONE_R + RW'(req_word.m11_delta);
      s1_u_ff <= req_word.shift_u;
      s1_v_ff <= req_word.shift_v;
   end

   // Stage 2: determinant products and divider numerators.
   // Lanes: 0 gives ri00 from r11, 1 ri10 from r10, 2 ri01 from r01, 3 ri11 from r00.
   logic                   s2_valid_ff;
   logic signed [2*RW-1:0] pa_ff, pb_ff;
   logic [3:0]             s2_rs_ff;
   logic [3:0][QW-1:0]     s2_num_ff;
   logic [3:0][QW-1:0]     s2_num_in;
   logic signed [W-1:0]    s2_u_ff, s2_v_ff;
   logic [3:0][RW-1:0]     lane_r;

   always_comb begin
      lane_r[0] = r11_ff;
      lane_r[1] = r10_ff;
      lane_r[2] = r01_ff;
      lane_r[3] = r00_ff;
      for (int j = 0; j < 4; j++) begin
         s2_num_in[j] = {(lane_r[j][RW-1] ? RW'(-lane_r[j]) : lane_r[j]),
                         {FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff     <= r00_ff * r11_ff;
      pb_ff     <= r01_ff * r10_ff;
      s2_rs_ff  <= {lane_r[3][RW-1], lane_r[2][RW-1], lane_r[1][RW-1], lane_r[0][RW-1]};
      s2_num_ff <= s2_num_in;
      s2_u_ff   <= s1_u_ff;
      s2_v_ff   <= s1_v_ff;
   end

   // Stage 3: determinant, floored and saturated to 64 bits.
   logic                 s3_valid_ff;
   logic signed [63:0]   det_ff;
   logic signed [63:0]   det_in;
   logic signed [PW-1:0] det_diff;
   logic signed [PW-1:0] det_shr;
   logic [3:0]           s3_rs_ff;
   logic [3:0][QW-1:0]   s3_num_ff;
   logic signed [W-1:0]  s3_u_ff, s3_v_ff;

   always_comb begin
      det_diff = PW'(pa_ff) - PW'(pb_ff);
      det_shr  = det_diff >>> FRAC_BITS;
      if ((&det_shr[PW-1:63]) || (~|det_shr[PW-1:63])) begin
         det_in = det_shr[63:0];
      end else begin
         det_in = {det_shr[PW-1], {63{~det_shr[PW-1]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      det_ff    <= det_in;
      s3_rs_ff  <= s2_rs_ff;
      s3_num_ff <= s2_num_ff;
      s3_u_ff   <= s2_u_ff;
      s3_v_ff   <= s2_v_ff;
   end

   // Stage 4: divisor magnitude, singular test and quotient signs.
   logic        head_valid_ff;
   div_type     head_ff;
   div_type     head_in;
   logic        det_sign;

   always_comb begin
      det_sign         = det_ff[63];
      head_in.d        = det_sign ? 64'(-det_ff) : det_ff;
      head_in.singular = (det_ff == '0) || (head_in.d < 64'(min_det_ff));
      head_in.neg[0]   = s3_rs_ff[0] ^ det_sign;
      head_in.neg[1]   = !(s3_rs_ff[1] ^ det_sign);
      head_in.neg[2]   = !(s3_rs_ff[2] ^ det_sign);
      head_in.neg[3]   = s3_rs_ff[3] ^ det_sign;
      head_in.u        = s3_u_ff;
      head_in.v        = s3_v_ff;
      head_in.rem      = '0;
      head_in.nq       = s3_num_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

   // Divider: one quotient bit per stage for all four lanes.
   logic [QW-1:0] div_valid_ff;
   div_type       div_ff [QW];
   div_type       div_in [QW];

   for (genvar k = 0; k < QW; k++) begin : g_div
      div_type src;
      logic    src_valid;
      if (k == 0) begin : g_first
         assign src       = head_ff;
         assign src_valid = head_valid_ff;
      end else begin : g_next
         assign src       = div_ff[k-1];
         assign src_valid = div_valid_ff[k-1];
      end

      always_comb begin
         logic [64:0] t;
         logic        ge;
         div_in[k] = src;
         for (int j = 0; j < 4; j++) begin
            t  = {src.rem[j], src.nq[j][QW-1]};
            ge = t >= {1'b0, src.d};
            div_in[k].rem[j] = ge ? 64'(t - {1'b0, src.d}) : t[63:0];
            div_in[k].nq[j]  = {src.nq[j][QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k] <= 1'b0;
         end else begin
            div_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         div_ff[k] <= div_in[k];
      end
   end

   // Signed inverse entries.
   logic                      sg_valid_ff;
   logic [3:0][IW-1:0]        sg_i_ff;
   logic [3:0][IW-1:0]        sg_i_in;
   logic                      sg_singular_ff;
   logic signed [W-1:0]       sg_u_ff, sg_v_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sg_i_in[j] = div_ff[QW-1].neg[j] ? IW'(-{1'b0, div_ff[QW-1].nq[j]}) :
                                            {1'b0, div_ff[QW-1].nq[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sg_valid_ff <= 1'b0;
      end else begin
         sg_valid_ff <= div_valid_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      sg_i_ff        <= sg_i_in;
      sg_singular_ff <= div_ff[QW-1].singular;
      sg_u_ff        <= div_ff[QW-1].u;
      sg_v_ff        <= div_ff[QW-1].v;
   end

   // Partial products of the translation terms and saturated matrix outputs.
   logic                    m1_valid_ff;
   logic signed [PLW-1:0]   pl_ff [4];
   logic signed [PHW-1:0]   ph_ff [4];
   logic signed [W-1:0]     m1_res_ff [4];
   logic signed [W-1:0]     m1_res_in [4];
   logic signed [W-1:0]     mul_x [4];
   logic                    m1_singular_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         mul_x[j] = (j < 2) ? sg_u_ff : sg_v_ff;
      end
      m1_res_in[0] = sat_w(TW'($signed(sg_i_ff[0])) - ONE_T);
      m1_res_in[1] = sat_w(TW'($signed(sg_i_ff[1])));
      m1_res_in[2] = sat_w(TW'($signed(sg_i_ff[2])));
      m1_res_in[3] = sat_w(TW'($signed(sg_i_ff[3])) - ONE_T);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= sg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 4; j++) begin
         pl_ff[j]     <= $signed({1'b0, sg_i_ff[j][L-1:0]}) * mul_x[j];
         ph_ff[j]     <= $signed(sg_i_ff[j][IW-1:L]) * mul_x[j];
         m1_res_ff[j] <= m1_res_in[j];
      end
      m1_singular_ff <= sg_singular_ff;
   end

   // Full products.
   logic                  m2_valid_ff;
   logic signed [PRW-1:0] prod_ff [4];
   logic signed [W-1:0]   m2_res_ff [4];
   logic                  m2_singular_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 4; j++) begin
         prod_ff[j]   <= (PRW'(ph_ff[j]) <<< L) + PRW'(pl_ff[j]);
         m2_res_ff[j] <= m1_res_ff[j];
      end
      m2_singular_ff <= m1_singular_ff;
   end

   // Output register: negated, floored translation and zeroing when singular.
   logic        out_valid_ff;
   api_rsp_type out_ff;
   api_rsp_type out_in;
   logic signed [TW-1:0] tu_neg, tv_neg;

   always_comb begin
      tu_neg = -(TW'(prod_ff[0]) + TW'(prod_ff[2]));
      tv_neg = -(TW'(prod_ff[1]) + TW'(prod_ff[3]));
      out_in.inv_m00_delta = m2_res_ff[0];
      out_in.inv_m10       = m2_res_ff[1];
      out_in.inv_m01       = m2_res_ff[2];
      out_in.inv_m11_delta = m2_res_ff[3];
      out_in.inv_shift_u   = sat_w(tu_neg >>> FRAC_BITS);
      out_in.inv_shift_v   = sat_w(tv_neg >>> FRAC_BITS);
      out_in.singular      = 1'b0;
      if (m2_singular_ff) begin
         out_in          = '0;
         out_in.singular = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_word   = out_ff;

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.singular |->
         rsp_word.inv_m00_delta == 0 && rsp_word.inv_m10 == 0 &&
         rsp_word.inv_m01 == 0 && rsp_word.inv_m11_delta == 0 &&
         rsp_word.inv_shift_u == 0 && rsp_word.inv_shift_v == 0)
      else $error("singular word carries nonzero fields");

   a_strobe_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result word without matching accepted word");

   a_min_det_write : assert property (@(posedge clock)
      !$stable(min_det_ff) |-> $past(csr_write) || $past(reset))
      else $error("min_det changed without a write");

endmodule
